// File: rtl/core/vks_pkg.sv
package vks_pkg;

	// Depth of the source tables; the six-bit entry index fixes it.
	localparam int MAX_SOURCES = 64;

	// Reciprocal of two pi in Q0.32, rounded.
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

	localparam int MUL_STEPS = 33;
	localparam int DIV_STEPS = 94;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	typedef struct packed {
		logic               mode;
		logic [5:0]         entry_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] strength;
		logic signed [31:0] vel_x_in;
		logic signed [31:0] vel_y_in;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] vel_x_out;
		logic signed [31:0] vel_y_out;
		logic               saturated;
	} result_t;

endpackage

// File: rtl/core/vortex_kernel_direct_sum.sv
// Channel    | Signals                     | Word
// -----------+-----------------------------+-------------------------------------
// command    | start, busy, cmd            | load one source or evaluate a target
// result     | done, result                | corrected velocity and clip flag
// config     | cfg_we, cfg_data            | source_count register
//
// A load word is taken at an idle edge, and busy stays low.
// An evaluate word holds busy high while the N sources in use are visited in turn: per
// source a table read, a difference step, six shift-add multiplications and two
// restoring divisions; a source at the target skips the multiplications and divisions.
// Reset clears the sequencer and sets source_count to 64; the tables hold no reset value.
// The result is shown for one cycle with done high as busy falls; the receiver cannot stall.
module vortex_kernel_direct_sum
	import vks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data
);

	localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CW = ($clog2(MAX_SOURCES + 1) > 7) ? $clog2(MAX_SOURCES + 1) : 7;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FETCH = 6'b000010,
		ST_DIFF  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	typedef enum logic [7:0] {
		PH_SQX = 8'b00000001,
		PH_SQY = 8'b00000010,
		PH_PX1 = 8'b00000100,
		PH_PX2 = 8'b00001000,
		PH_DVX = 8'b00010000,
		PH_PY1 = 8'b00100000,
		PH_PY2 = 8'b01000000,
		PH_DVY = 8'b10000000
	} phase_t;

	// Source tables, one synchronous read port each.
	logic [31:0] mem_x [MAX_SOURCES];
	logic [31:0] mem_y [MAX_SOURCES];
	logic [31:0] mem_s [MAX_SOURCES];
	logic [31:0] rd_x_q, rd_y_q, rd_s_q;

	state_t state_q;
	phase_t phase_q;
	logic [6:0]  count_cfg_q;
	logic [CW-1:0] count_q, j_q;
	logic [6:0]  cnt_q;

	logic signed [31:0] tx_q, ty_q, vx_q, vy_q;
	logic [32:0] dxm_q, dym_q;
	logic        dxn_q, dyn_q, sn_q;
	logic [31:0] sm_q;
	logic [65:0] r_q;
	logic [81:0] den_q;
	logic [63:0] sum_x_q, sum_y_q;

	logic [96:0] ma_q, acc_q;
	logic [32:0] mb_q;
	logic [93:0] num_q;
	logic [94:0] rem_q;
	logic [63:0] quo_q;

	logic        accept, is_load;
	logic [CW-1:0] cfg_wide, eff_count;
	logic [32:0] dx, dy;
	logic [96:0] acc_nx;
	logic [94:0] rem_sh, rem_nx;
	logic        ge;
	logic [63:0] quo_nx, term;
	logic        term_neg;
	logic [65:0] r_sum;
	logic [63:0] fin_x, fin_y;
	logic        clip_x, clip_y;
	logic [31:0] sat_x, sat_y;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign is_load = (cmd.mode == MODE_LOAD);

	assign cfg_wide  = CW'(count_cfg_q);
	assign eff_count = (cfg_wide > CW'(MAX_SOURCES)) ? CW'(MAX_SOURCES) : cfg_wide;

	always_ff @(posedge clk) begin
		if (accept && is_load && ({1'b0, cmd.entry_index} < 7'(MAX_SOURCES))) begin
			mem_x[cmd.entry_index[AW-1:0]] <= cmd.point_x;
			mem_y[cmd.entry_index[AW-1:0]] <= cmd.point_y;
			mem_s[cmd.entry_index[AW-1:0]] <= cmd.strength;
		end
		rd_x_q <= mem_x[j_q[AW-1:0]];
		rd_y_q <= mem_y[j_q[AW-1:0]];
		rd_s_q <= mem_s[j_q[AW-1:0]];
	end

	// Differences of target and source, 33 bits signed.
	assign dx = {tx_q[31], tx_q} - {rd_x_q[31], rd_x_q};
	assign dy = {ty_q[31], ty_q} - {rd_y_q[31], rd_y_q};

	// One step of the shift-add multiplier.
	assign acc_nx = acc_q + (mb_q[0] ? ma_q : 97'd0);

	// One step of the restoring divider.
	assign rem_sh = {rem_q[93:0], num_q[93]};
	assign ge     = (rem_sh >= {13'd0, den_q});
	assign rem_nx = ge ? (rem_sh - {13'd0, den_q}) : rem_sh;
	assign quo_nx = {quo_q[62:0], ge};

	assign term_neg = (phase_q == PH_DVX) ? (sn_q ^ dyn_q) : (sn_q ^ dxn_q);
	assign term     = term_neg ? (64'd0 - quo_nx) : quo_nx;
	assign r_sum    = r_q + acc_nx[65:0];

	// Final sums with the input velocity, then clipping to 32 bits.
	assign fin_x  = sum_x_q + {{32{vx_q[31]}}, vx_q};
	assign fin_y  = sum_y_q + {{32{vy_q[31]}}, vy_q};
	assign clip_x = (fin_x[63:31] != {33{fin_x[63]}});
	assign clip_y = (fin_y[63:31] != {33{fin_y[63]}});
	assign sat_x  = clip_x ? (fin_x[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : fin_x[31:0];
	assign sat_y  = clip_y ? (fin_y[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : fin_y[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_SQX;
			count_cfg_q <= 7'd64;
			done        <= 1'b0;
			j_q         <= '0;
			cnt_q       <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				count_cfg_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && !is_load) begin
						j_q     <= '0;
						count_q <= eff_count;
						sum_x_q <= '0;
						sum_y_q <= '0;
						state_q <= (eff_count == '0) ? ST_FIN : ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (dx == '0 && dy == '0) begin
						// A source at the target adds nothing.
						if (j_q + 1'b1 == count_q) begin
							state_q <= ST_FIN;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= ST_FETCH;
						end
					end else begin
						state_q <= ST_MUL;
						phase_q <= PH_SQX;
						cnt_q   <= '0;
						acc_q   <= '0;
						ma_q    <= {64'd0, dx[32] ? (33'd0 - dx) : dx};
						mb_q    <= dx[32] ? (33'd0 - dx) : dx;
					end
				end
				ST_MUL: begin
					acc_q <= acc_nx;
					ma_q  <= {ma_q[95:0], 1'b0};
					mb_q  <= {1'b0, mb_q[32:1]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(MUL_STEPS - 1)) begin
						cnt_q <= '0;
						acc_q <= '0;
						case (phase_q)
							PH_SQX: begin
								r_q     <= acc_nx[65:0];
								phase_q <= PH_SQY;
								ma_q    <= {64'd0, dym_q};
								mb_q    <= dym_q;
							end
							PH_SQY: begin
								den_q   <= {r_sum, 16'd0};
								phase_q <= PH_PX1;
								ma_q    <= {65'd0, sm_q};
								mb_q    <= dym_q;
							end
							PH_PX1: begin
								phase_q <= PH_PX2;
								ma_q    <= {33'd0, acc_nx[63:0]};
								mb_q    <= {3'd0, INV_TWO_PI_Q32};
							end
							PH_PY1: begin
								phase_q <= PH_PY2;
								ma_q    <= {33'd0, acc_nx[63:0]};
								mb_q    <= {3'd0, INV_TWO_PI_Q32};
							end
							PH_PX2: begin
								num_q   <= acc_nx[93:0];
								rem_q   <= '0;
								quo_q   <= '0;
								phase_q <= PH_DVX;
								state_q <= ST_DIV;
							end
							PH_PY2: begin
								num_q   <= acc_nx[93:0];
								rem_q   <= '0;
								quo_q   <= '0;
								phase_q <= PH_DVY;
								state_q <= ST_DIV;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					num_q <= {num_q[92:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 7'(DIV_STEPS - 1)) begin
						cnt_q <= '0;
						if (phase_q == PH_DVX) begin
							sum_x_q <= sum_x_q - term;
							phase_q <= PH_PY1;
							state_q <= ST_MUL;
							acc_q   <= '0;
							ma_q    <= {65'd0, sm_q};
							mb_q    <= dxm_q;
						end else begin
							sum_y_q <= sum_y_q + term;
							if (j_q + 1'b1 == count_q) begin
								state_q <= ST_FIN;
							end else begin
								j_q     <= j_q + 1'b1;
								state_q <= ST_FETCH;
							end
						end
					end
				end
				ST_FIN: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (accept && !is_load) begin
			tx_q    <= cmd.point_x;
			ty_q    <= cmd.point_y;
			vx_q    <= cmd.vel_x_in;
			vy_q    <= cmd.vel_y_in;
		end
		if (state_q == ST_DIFF) begin
			dxm_q <= dx[32] ? (33'd0 - dx) : dx;
			dym_q <= dy[32] ? (33'd0 - dy) : dy;
			dxn_q <= dx[32];
			dyn_q <= dy[32];
			sn_q  <= rd_s_q[31];
			sm_q  <= rd_s_q[31] ? (32'd0 - rd_s_q) : rd_s_q;
		end
		if (state_q == ST_FIN) begin
			result.vel_x_out <= sat_x;
			result.vel_y_out <= sat_y;
			result.saturated <= clip_x | clip_y;
		end
	end

endmodule
